### sv/lsac_pkg.sv
// ----------------------------------------------------------------------------
// lsac_pkg
// Types and constants shared by the limit-switch actuator control block.
// ----------------------------------------------------------------------------
package lsac_pkg;

  localparam int unsigned PWM_TOP = 200;
  localparam logic [15:0] DUTY_HALF = 16'(PWM_TOP / 2);

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_RETRACT    = 3'd1,
    MODE_FORCE_RET  = 3'd2,
    MODE_EXTEND     = 3'd3,
    MODE_MAN_EXTEND = 3'd4,
    MODE_TEST_EXT   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_RUN       = 3'd0,
    ST_STOP_IN   = 3'd1,
    ST_STOP_FOOT = 3'd2,
    ST_STOP_OUT  = 3'd3,
    ST_ANGLE     = 3'd4,
    ST_GROUND    = 3'd5,
    ST_FOOT_LEFT = 3'd6,
    ST_IDLE      = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    LATCH_NONE = 2'd0,
    LATCH_IN   = 2'd1,
    LATCH_OUT  = 2'd2
  } latch_t;

  localparam logic DIR_EXTEND  = 1'b0;
  localparam logic DIR_RETRACT = 1'b1;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] speed_target;
    logic       in_limit;
    logic       out_limit;
    logic       foot_contact;
    logic       angle_low;
    logic       ground_contact;
    logic       fault_n;
    logic       tick;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        direction;
    logic [15:0] duty;
    logic        reset_pulse;
    logic        driving;
  } out_item_t;

  // mode decision handed from the decoder to the top level
  typedef struct packed {
    logic [2:0] status;
    logic       drive;
    logic [1:0] latch;
    logic       dir;
  } dec_t;

  typedef struct packed {
    logic [15:0] duty;
    logic        tick_pend;
    logic        pulse;
  } ramp_t;

endpackage

### sv/lsac_if.sv
// ----------------------------------------------------------------------------
// lsac_in_if / lsac_out_if
// Valid/ready channels for poll items and result items.
// ----------------------------------------------------------------------------
interface lsac_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] speed_target;
  logic       in_limit;
  logic       out_limit;
  logic       foot_contact;
  logic       angle_low;
  logic       ground_contact;
  logic       fault_n;
  logic       tick;

  modport source (
    output valid, mode, speed_target, in_limit, out_limit, foot_contact,
           angle_low, ground_contact, fault_n, tick,
    input  ready
  );
  modport sink (
    input  valid, mode, speed_target, in_limit, out_limit, foot_contact,
           angle_low, ground_contact, fault_n, tick,
    output ready
  );
endinterface

interface lsac_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        direction;
  logic [15:0] duty;
  logic        reset_pulse;
  logic        driving;

  modport source (
    output valid, status, direction, duty, reset_pulse, driving,
    input  ready
  );
  modport sink (
    input  valid, status, direction, duty, reset_pulse, driving,
    output ready
  );
endinterface

### sv/lsac_decode.sv
// ----------------------------------------------------------------------------
// lsac_decode
// Per-mode stop checks: status, drive request, end latch and direction.
// ----------------------------------------------------------------------------
module lsac_decode (
  input  lsac_pkg::in_item_t item,
  input  logic [2:0]         last_mode,
  input  logic [1:0]         end_latch,
  output lsac_pkg::dec_t     dec
);
  import lsac_pkg::*;

  logic [1:0] latch_cur;

  // a mode change drops any latched end position
  assign latch_cur = (item.mode != last_mode) ? LATCH_NONE : end_latch;

  always_comb begin
    dec.status = ST_RUN;
    dec.drive  = 1'b0;
    dec.latch  = latch_cur;
    dec.dir    = DIR_EXTEND;
    case (item.mode)
      MODE_RETRACT: begin
        dec.dir = DIR_RETRACT;
        if (item.in_limit || latch_cur == LATCH_IN) begin
          dec.latch  = LATCH_IN;
          dec.status = ST_STOP_IN;
        end else if (item.foot_contact) begin
          dec.status = ST_STOP_FOOT;
        end else begin
          dec.latch = LATCH_NONE;
          dec.drive = 1'b1;
        end
      end
      MODE_FORCE_RET: begin
        dec.dir = DIR_RETRACT;
        if (item.in_limit || latch_cur == LATCH_IN) begin
          dec.latch  = LATCH_IN;
          dec.status = ST_STOP_IN;
        end else begin
          dec.latch = LATCH_NONE;
          dec.drive = 1'b1;
        end
      end
      MODE_EXTEND: begin
        if (item.out_limit || latch_cur == LATCH_OUT) begin
          dec.latch  = LATCH_OUT;
          dec.status = ST_STOP_OUT;
        end else if (item.angle_low) begin
          dec.status = ST_ANGLE;
        end else if (item.ground_contact) begin
          dec.status = ST_GROUND;
        end else if (!item.foot_contact) begin
          dec.status = ST_FOOT_LEFT;
        end else begin
          dec.latch = LATCH_NONE;
          dec.drive = 1'b1;
        end
      end
      MODE_MAN_EXTEND: begin
        if (item.out_limit || latch_cur == LATCH_OUT) begin
          dec.latch  = LATCH_OUT;
          dec.status = ST_STOP_OUT;
        end else if (item.ground_contact) begin
          dec.status = ST_GROUND;
        end else if (item.angle_low) begin
          dec.status = ST_ANGLE;
        end else begin
          dec.latch = LATCH_NONE;
          dec.drive = 1'b1;
        end
      end
      MODE_TEST_EXT: begin
        dec.latch = LATCH_NONE;
        dec.drive = 1'b1;
      end
      MODE_IDLE: begin
        dec.latch  = LATCH_NONE;
        dec.status = ST_IDLE;
      end
      default: begin
        // unknown mode brakes, latch kept
        dec.status = ST_RUN;
      end
    endcase
  end

endmodule

### sv/lsac_ramp.sv
// ----------------------------------------------------------------------------
// lsac_ramp
// PWM duty ramp step, tick bookkeeping and driver reset pulse.
// ----------------------------------------------------------------------------
module lsac_ramp (
  input  logic              drive,
  input  logic [7:0]        target,
  input  logic              fault_n,
  input  logic              tick_pend,
  input  logic [15:0]       duty,
  output lsac_pkg::ramp_t   ramp
);
  import lsac_pkg::*;

  logic [15:0] target_w;

  assign target_w = {8'd0, target};

  always_comb begin
    ramp.duty      = duty;
    ramp.tick_pend = tick_pend;
    ramp.pulse     = 1'b0;
    if (!drive || target == 8'd0) begin
      ramp.duty = 16'd0;
    end else if (duty == target_w) begin
      ramp.pulse = ~fault_n;
    end else if (tick_pend) begin
      ramp.tick_pend = 1'b0;
      // first step jumps to half scale; above target the duty is held
      if (duty < target_w) begin
        ramp.duty = (duty < DUTY_HALF) ? DUTY_HALF : duty + 16'd1;
      end
    end
  end

endmodule

### sv/limit_switch_actuator_control.sv
// ----------------------------------------------------------------------------
// limit_switch_actuator_control
// Actuator mode control with limit-switch stops and a ticked PWM duty ramp.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one poll per transfer: requested mode, speed target, the
//          five switch levels, the driver fault line and the tick bit.
//   out_ch returns exactly one result per poll: status, direction, duty,
//          reset pulse and the drive request, in poll order.
//   A poll is registered on transfer, decoded and ramped from the input
//   register and written into the result register. One poll per cycle is
//   sustained while out_ch is not stalled; the rate is set by the single
//   decode-and-ramp step between the two registers, which also updates the
//   mode, latch, duty and tick state.
//   While out_ch is stalled the result holds; one more poll can wait in the
//   input register, after which in_ch.ready drops until the result moves.
//   Synchronous reset clears both pipeline stages and returns the state to
//   idle mode, no end latched, zero duty, no pending tick, extend direction.
// ----------------------------------------------------------------------------
module limit_switch_actuator_control (
  input  logic         clk,
  input  logic         rst_n,
  lsac_in_if.sink      in_ch,
  lsac_out_if.source   out_ch
);
  import lsac_pkg::*;

  logic        s1_valid_r;
  in_item_t    s1_r;
  logic        out_valid_r;
  out_item_t   out_r;
  logic [2:0]  last_mode_r;
  logic [1:0]  end_latch_r;
  logic [15:0] duty_r;
  logic        tick_pend_r;
  logic        dir_r;

  logic        s1_adv;
  logic        in_xfer;
  logic        dir_nxt;
  out_item_t   out_nxt;
  dec_t        dec;
  ramp_t       ramp;

  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  lsac_decode u_decode (
    .item      (s1_r),
    .last_mode (last_mode_r),
    .end_latch (end_latch_r),
    .dec       (dec)
  );

  lsac_ramp u_ramp (
    .drive     (dec.drive),
    .target    (s1_r.speed_target),
    .fault_n   (s1_r.fault_n),
    .tick_pend (tick_pend_r | s1_r.tick),
    .duty      (duty_r),
    .ramp      (ramp)
  );

  assign dir_nxt = dec.drive ? dec.dir : dir_r;

  always_comb begin
    out_nxt.status      = dec.status;
    out_nxt.direction   = dir_nxt;
    out_nxt.duty        = ramp.duty;
    out_nxt.reset_pulse = ramp.pulse;
    out_nxt.driving     = dec.drive;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      last_mode_r <= MODE_IDLE;
      end_latch_r <= LATCH_NONE;
      duty_r      <= 16'd0;
      tick_pend_r <= 1'b0;
      dir_r       <= DIR_EXTEND;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        last_mode_r <= s1_r.mode;
        end_latch_r <= dec.latch;
        duty_r      <= ramp.duty;
        tick_pend_r <= ramp.tick_pend;
        dir_r       <= dir_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r.mode           <= in_ch.mode;
      s1_r.speed_target   <= in_ch.speed_target;
      s1_r.in_limit       <= in_ch.in_limit;
      s1_r.out_limit      <= in_ch.out_limit;
      s1_r.foot_contact   <= in_ch.foot_contact;
      s1_r.angle_low      <= in_ch.angle_low;
      s1_r.ground_contact <= in_ch.ground_contact;
      s1_r.fault_n        <= in_ch.fault_n;
      s1_r.tick           <= in_ch.tick;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.direction   = out_r.direction;
  assign out_ch.duty        = out_r.duty;
  assign out_ch.reset_pulse = out_r.reset_pulse;
  assign out_ch.driving     = out_r.driving;

`ifndef SYNTH
  a_brake_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.driving |-> out_r.duty == 16'd0)
    else $error("braking result with nonzero duty");

  a_pulse_when_driving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.reset_pulse |-> out_r.driving && out_r.duty != 16'd0)
    else $error("reset pulse without active drive");

  a_ramp_floor: assert property (@(posedge clk) disable iff (!rst_n)
    duty_r != 16'd0 |-> duty_r >= DUTY_HALF)
    else $error("duty below half scale while driving");

  a_latch_code: assert property (@(posedge clk) disable iff (!rst_n)
    end_latch_r == LATCH_NONE || end_latch_r == LATCH_IN || end_latch_r == LATCH_OUT)
    else $error("end latch holds unused code");

  a_state_follows_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_r.duty == duty_r && out_r.direction == dir_r)
    else $error("state and result register out of step");
`endif

endmodule

### tb/sv/tb_limit_switch_actuator_control.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_limit_switch_actuator_control
// Drives polls into the actuator control block through valid/ready channels.
// A shadow copy of the mode, end latch, duty ramp and tick state predicts
// each result, which is compared field by field as it leaves the block.
// A directed run covers every mode and stop condition. Random runs of
// steady modes with random switch levels follow, under several idle and
// stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_limit_switch_actuator_control;
  import lsac_pkg::*;

  localparam logic [2:0]  MODE_SPARE_LO = 3'd6;
  localparam logic [2:0]  MODE_SPARE_HI = 3'd7;
  localparam int          IN_BITS       = $bits(in_item_t);
  localparam int unsigned PHASE_POLLS   = 450;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned MAX_REPORTS   = 40;

  // Shadow of the block state; predicts one result per accepted poll.
  class actuator_shadow;
    logic [2:0]  prev_mode;
    latch_t      latch;
    logic [15:0] duty;
    logic        tick_pend;
    logic        dir;
    out_item_t   due_results[$];
    int unsigned errors;

    function new();
      prev_mode = MODE_IDLE;
      latch     = LATCH_NONE;
      duty      = '0;
      tick_pend = 1'b0;
      dir       = DIR_EXTEND;
      errors    = 0;
    endfunction

    function void note_poll(in_item_t p);
      status_t     st;
      logic        drv;
      logic        pulse;
      logic [15:0] tgt_w;
      out_item_t   r;
      st    = ST_RUN;
      drv   = 1'b0;
      pulse = 1'b0;
      tgt_w = {8'd0, p.speed_target};
      if (p.tick) tick_pend = 1'b1;
      if (p.mode != prev_mode) begin
        prev_mode = p.mode;
        latch     = LATCH_NONE;
      end
      case (p.mode)
        MODE_RETRACT, MODE_FORCE_RET: begin
          if (p.in_limit || latch == LATCH_IN) begin
            latch = LATCH_IN;
            st    = ST_STOP_IN;
          end else if (p.mode == MODE_RETRACT && p.foot_contact) begin
            st = ST_STOP_FOOT;
          end else begin
            latch = LATCH_NONE;
            dir   = DIR_RETRACT;
            drv   = 1'b1;
          end
        end
        MODE_EXTEND: begin
          if (p.out_limit || latch == LATCH_OUT) begin
            latch = LATCH_OUT;
            st    = ST_STOP_OUT;
          end else if (p.angle_low) begin
            st = ST_ANGLE;
          end else if (p.ground_contact) begin
            st = ST_GROUND;
          end else if (!p.foot_contact) begin
            st = ST_FOOT_LEFT;
          end else begin
            latch = LATCH_NONE;
            dir   = DIR_EXTEND;
            drv   = 1'b1;
          end
        end
        MODE_MAN_EXTEND: begin
          // ground is checked ahead of angle here, unlike normal extend
          if (p.out_limit || latch == LATCH_OUT) begin
            latch = LATCH_OUT;
            st    = ST_STOP_OUT;
          end else if (p.ground_contact) begin
            st = ST_GROUND;
          end else if (p.angle_low) begin
            st = ST_ANGLE;
          end else begin
            latch = LATCH_NONE;
            dir   = DIR_EXTEND;
            drv   = 1'b1;
          end
        end
        MODE_TEST_EXT: begin
          latch = LATCH_NONE;
          dir   = DIR_EXTEND;
          drv   = 1'b1;
        end
        MODE_IDLE: begin
          latch = LATCH_NONE;
          st    = ST_IDLE;
        end
        default: ;
      endcase
      if (!drv) begin
        duty = '0;
      end else if (p.speed_target == '0) begin
        duty = '0;
      end else if (duty == tgt_w) begin
        pulse = !p.fault_n;
      end else if (tick_pend) begin
        // a duty above the target still uses up the tick
        tick_pend = 1'b0;
        if (duty < tgt_w) duty = (duty < DUTY_HALF) ? DUTY_HALF : duty + 16'd1;
      end
      r.status      = st;
      r.direction   = dir;
      r.duty        = duty;
      r.reset_pulse = pulse;
      r.driving     = drv;
      due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual status %0d duty %0d",
                   $time, got.status, got.duty);
        return;
      end
      want = due_results.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("direction", 16'(want.direction), 16'(got.direction));
      compare_field("duty", want.duty, got.duty);
      compare_field("reset_pulse", 16'(want.reset_pulse), 16'(got.reset_pulse));
      compare_field("driving", 16'(want.driving), 16'(got.driving));
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  int unsigned    send_idle_pct;
  int unsigned    stall_pct;
  int unsigned    cycle_cnt;
  actuator_shadow shadow;

  lsac_in_if  in_ch ();
  lsac_out_if out_ch ();

  limit_switch_actuator_control uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status      = out_ch.status;
      got.direction   = out_ch.direction;
      got.duty        = out_ch.duty;
      got.reset_pulse = out_ch.reset_pulse;
      got.driving     = out_ch.driving;
      shadow.check_result(got);
    end
  end

  // switch bits: {in_limit, out_limit, foot, angle, ground, fault_n, tick}
  function automatic in_item_t make_poll(logic [2:0] m, logic [7:0] tgt, logic [6:0] sw);
    in_item_t p;
    p.mode           = m;
    p.speed_target   = tgt;
    p.in_limit       = sw[6];
    p.out_limit      = sw[5];
    p.foot_contact   = sw[4];
    p.angle_low      = sw[3];
    p.ground_contact = sw[2];
    p.fault_n        = sw[1];
    p.tick           = sw[0];
    return p;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_poll(input in_item_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= p.mode;
    in_ch.speed_target   <= p.speed_target;
    in_ch.in_limit       <= p.in_limit;
    in_ch.out_limit      <= p.out_limit;
    in_ch.foot_contact   <= p.foot_contact;
    in_ch.angle_low      <= p.angle_low;
    in_ch.ground_contact <= p.ground_contact;
    in_ch.fault_n        <= p.fault_n;
    in_ch.tick           <= p.tick;
    do @(posedge clk); while (!in_ch.ready);
    shadow.note_poll(p);
    @(negedge clk);
  endtask

  task automatic run_directed();
    send_poll(make_poll(MODE_IDLE,       8'd0,   7'b0000010));
    send_poll(make_poll(MODE_EXTEND,     8'd255, 7'b0010011));
    send_poll(make_poll(MODE_EXTEND,     8'd255, 7'b0010011));
    // duty at target with driver fault
    send_poll(make_poll(MODE_EXTEND,     8'd101, 7'b0010000));
    send_poll(make_poll(MODE_EXTEND,     8'd50,  7'b0010011));
    send_poll(make_poll(MODE_EXTEND,     8'd0,   7'b0010010));
    send_poll(make_poll(MODE_EXTEND,     8'd255, 7'b0110010));
    send_poll(make_poll(MODE_EXTEND,     8'd255, 7'b0010010));
    send_poll(make_poll(MODE_EXTEND,     8'd255, 7'b0011110));
    send_poll(make_poll(MODE_MAN_EXTEND, 8'd255, 7'b0000110));
    send_poll(make_poll(MODE_MAN_EXTEND, 8'd255, 7'b0001010));
    send_poll(make_poll(MODE_MAN_EXTEND, 8'd255, 7'b0000011));
    send_poll(make_poll(MODE_EXTEND,     8'd255, 7'b0001110));
    send_poll(make_poll(MODE_EXTEND,     8'd255, 7'b0010110));
    send_poll(make_poll(MODE_EXTEND,     8'd255, 7'b0000010));
    send_poll(make_poll(MODE_RETRACT,    8'd255, 7'b1010010));
    send_poll(make_poll(MODE_RETRACT,    8'd255, 7'b0010011));
    send_poll(make_poll(MODE_FORCE_RET,  8'd255, 7'b0010011));
    send_poll(make_poll(MODE_RETRACT,    8'd255, 7'b0010010));
    send_poll(make_poll(MODE_RETRACT,    8'd255, 7'b0000011));
    send_poll(make_poll(MODE_SPARE_LO,   8'd255, 7'b1111111));
    send_poll(make_poll(MODE_SPARE_HI,   8'd0,   7'b0000000));
    // tick left pending by a braking poll, then used by the next drive
    send_poll(make_poll(MODE_IDLE,       8'd255, 7'b0000001));
    send_poll(make_poll(MODE_TEST_EXT,   8'd255, 7'b1111110));
    send_poll(make_poll(MODE_FORCE_RET,  8'd255, 7'b1000001));
  endtask

  // runs of one steady mode so ramps and latches build up; some runs are noise
  task automatic run_random(input int unsigned n_polls);
    int unsigned sent;
    int unsigned run_len;
    logic [2:0]  m;
    logic [7:0]  tgt;
    bit          noise;
    bit          fwd;
    in_item_t    p;
    sent = 0;
    while (sent < n_polls) begin
      noise = ($urandom_range(6) == 0);
      if ($urandom_range(9) == 0) m = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
      else m = 3'($urandom_range(MODE_TEST_EXT));
      case ($urandom_range(9))
        0, 1, 2, 3: tgt = 8'($urandom_range(DUTY_HALF + 30, DUTY_HALF));
        4, 5, 6:    tgt = 8'($urandom_range(255, DUTY_HALF + 31));
        7:          tgt = 8'($urandom_range(DUTY_HALF, 1));
        8:          tgt = '0;
        default:    tgt = 8'($urandom);
      endcase
      fwd = (m == MODE_EXTEND || m == MODE_MAN_EXTEND || m == MODE_TEST_EXT);
      run_len = $urandom_range(40, 1);
      repeat (run_len) begin
        if (sent >= n_polls) break;
        if (noise) begin
          p = in_item_t'(IN_BITS'($urandom));
        end else begin
          if ($urandom_range(19) == 0) tgt = 8'($urandom);
          p.mode           = m;
          p.speed_target   = tgt;
          p.in_limit       = ($urandom_range(15) == 0);
          p.out_limit      = ($urandom_range(15) == 0);
          p.foot_contact   = fwd ? ($urandom_range(7) != 0) : ($urandom_range(7) == 0);
          p.angle_low      = ($urandom_range(11) == 0);
          p.ground_contact = ($urandom_range(11) == 0);
          p.fault_n        = ($urandom_range(7) != 0);
          p.tick           = 1'($urandom_range(1));
        end
        send_poll(p);
        sent++;
      end
    end
  endtask

  initial begin
    shadow               = new();
    cycle_cnt            = 0;
    send_idle_pct        = 0;
    stall_pct            = 0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.mode           = MODE_IDLE;
    in_ch.speed_target   = '0;
    in_ch.in_limit       = 1'b0;
    in_ch.out_limit      = 1'b0;
    in_ch.foot_contact   = 1'b0;
    in_ch.angle_low      = 1'b0;
    in_ch.ground_contact = 1'b0;
    in_ch.fault_n        = 1'b1;
    in_ch.tick           = 1'b0;
    out_ch.ready         = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    run_random(PHASE_POLLS);
    send_idle_pct = 71;
    run_random(PHASE_POLLS);
    send_idle_pct = 0;
    stall_pct     = 71;
    run_random(PHASE_POLLS);
    send_idle_pct = 6;
    stall_pct     = 6;
    run_random(PHASE_POLLS);
    in_ch.valid <= 1'b0;

    while (shadow.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
